// File: rtl/assert_macros.svh
// Assertion macros shared by the checker files.
// No dependencies; included by files that carry concurrent assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, held off while reset is asserted.
`define BMID_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, held off while reset is asserted.
`define BMID_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/bmid_pkg.sv
// Shared constants, codes and control types for the bitmap ID allocator.
// No dependencies.
package bmid_pkg;

  localparam int DEF_NUM_IDS   = 256;
  localparam int DEF_WORD_BITS = 32;

  localparam int OP_W      = 2;
  localparam int IDX_W     = 16;
  localparam int ST_W      = 2;
  localparam int CNT_OUT_W = 17;

  localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
  localparam logic [OP_W-1:0] OP_REMOVE = 2'd1;
  localparam logic [OP_W-1:0] OP_TEST   = 2'd2;
  localparam logic [OP_W-1:0] OP_ALLOC  = 2'd3;

  localparam logic [ST_W-1:0] ST_OK    = 2'd0;
  localparam logic [ST_W-1:0] ST_RANGE = 2'd1;
  localparam logic [ST_W-1:0] ST_FULL  = 2'd2;

  // controller -> datapath
  typedef struct packed {
    logic accept;     // request taken this cycle
    logic sgl_eval;   // evaluate insert/remove/test on the fetched word
    logic scan_eval;  // evaluate one fetched word of the allocate scan
    logic clr_step;   // zero one word of the bitmap
    logic load_out;   // move staged result into the output register
  } bmid_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic op_alloc;
    logic range_bad;
    logic scan_free;
    logic scan_last;
    logic clr_last;
    logic out_free;
  } bmid_sts_t;

endpackage

// File: rtl/bmid_if.sv
// Request and response channel interfaces for the bitmap ID allocator.
// Depends on bmid_pkg.
interface bmid_req_if import bmid_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [OP_W-1:0]  opcode;
  logic [IDX_W-1:0] index;

  modport source (output valid, output opcode, output index, input ready);
  modport sink   (input valid, input opcode, input index, output ready);
endinterface

interface bmid_rsp_if import bmid_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic                 was_member;
  logic [IDX_W-1:0]     alloc_index;
  logic [ST_W-1:0]      status;
  logic [CNT_OUT_W-1:0] member_count;

  modport source (output valid, output was_member, output alloc_index, output status,
                  output member_count, input ready);
  modport sink   (input valid, input was_member, input alloc_index, input status,
                  input member_count, output ready);
endinterface

// File: rtl/bmid_ctrl.sv
// Sequencing state machine of the bitmap ID allocator.
// Depends on bmid_pkg.
module bmid_ctrl import bmid_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  bmid_sts_t sts,
  output bmid_cmd_t cmd
);

  localparam logic [2:0] S_CLR  = 3'd0;
  localparam logic [2:0] S_IDLE = 3'd1;
  localparam logic [2:0] S_SGL  = 3'd2;
  localparam logic [2:0] S_SCAN = 3'd3;
  localparam logic [2:0] S_FIN  = 3'd4;

  logic [2:0] state_r;
  logic [2:0] state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    case (state_r)
      S_CLR: begin
        cmd.clr_step = 1'b1;
        if (sts.clr_last) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.accept = 1'b1;
          if (sts.op_alloc) begin
            state_nxt = S_SCAN;
          end else if (sts.range_bad) begin
            state_nxt = S_FIN;
          end else begin
            state_nxt = S_SGL;
          end
        end
      end
      S_SGL: begin
        cmd.sgl_eval = 1'b1;
        state_nxt    = S_FIN;
      end
      S_SCAN: begin
        cmd.scan_eval = 1'b1;
        if (sts.scan_free || sts.scan_last) begin
          state_nxt = S_FIN;
        end
      end
      S_FIN: begin
        // wait for the output register to drain
        if (sts.out_free) begin
          cmd.load_out = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_CLR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLR;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// File: rtl/bmid_dp.sv
// Datapath of the bitmap ID allocator: bitmap memory, count, result staging.
// Depends on bmid_pkg; driven by bmid_ctrl commands.
module bmid_dp import bmid_pkg::*; #(
  parameter int NUM_IDS   = DEF_NUM_IDS,
  parameter int WORD_BITS = DEF_WORD_BITS
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  bmid_cmd_t            cmd,
  output bmid_sts_t            sts,
  input  logic [OP_W-1:0]      in_opcode,
  input  logic [IDX_W-1:0]     in_index,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic                 out_was_member,
  output logic [IDX_W-1:0]     out_alloc_index,
  output logic [ST_W-1:0]      out_status,
  output logic [CNT_OUT_W-1:0] out_member_count
);

  localparam int NUM_WORDS = (NUM_IDS + WORD_BITS - 1) / WORD_BITS;
  localparam int BIT_W     = $clog2(WORD_BITS);
  localparam int WADDR_W   = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
  localparam int CNT_W     = $clog2(NUM_IDS + 1);
  localparam int TAIL      = NUM_IDS - (NUM_WORDS - 1) * WORD_BITS;

  localparam logic [WADDR_W-1:0]   LAST_ADDR = WADDR_W'(NUM_WORDS - 1);
  localparam logic [WORD_BITS-1:0] ONE       = WORD_BITS'(1);
  // bits of the last word past NUM_IDS read as taken during the scan
  localparam logic [WORD_BITS-1:0] PAD_MASK  = ~((ONE << TAIL) - ONE);
  localparam logic [IDX_W:0]       RANGE_LIM = (IDX_W + 1)'(NUM_IDS);

  function automatic logic [BIT_W-1:0] oh_enc(input logic [WORD_BITS-1:0] oh);
    logic [BIT_W-1:0] r;
    r = '0;
    for (int i = 0; i < WORD_BITS; i++) begin
      if (oh[i]) begin
        r = r | BIT_W'(i);
      end
    end
    return r;
  endfunction

  logic [WORD_BITS-1:0] mem [NUM_WORDS];

  logic [WORD_BITS-1:0] rd_word_r;
  logic [WADDR_W-1:0]   rd_addr_r;
  logic [OP_W-1:0]      op_r;
  logic [IDX_W-1:0]     idx_r;
  logic [WADDR_W-1:0]   clr_addr_r;
  logic [CNT_W-1:0]     count_r;
  logic [CNT_W-1:0]     count_nxt;
  logic [WADDR_W-1:0]   hit_addr_r;
  logic [WORD_BITS-1:0] iso_r;
  logic                 alloc_ok_r;
  logic                 res_was_r;
  logic [ST_W-1:0]      res_status_r;
  logic                 out_valid_r;
  logic                 out_was_r;
  logic [IDX_W-1:0]     out_alloc_r;
  logic [ST_W-1:0]      out_status_r;
  logic [CNT_OUT_W-1:0] out_count_r;

  logic                 range_bad;
  logic                 op_alloc;
  logic [WORD_BITS-1:0] scan_word;
  logic [WORD_BITS-1:0] scan_inc;
  logic                 scan_free;
  logic                 scan_last;
  logic [BIT_W-1:0]     bit_pos;
  logic [WORD_BITS-1:0] bit_oh;
  logic                 was;
  logic                 do_set;
  logic                 do_clr;

  logic                 we;
  logic [WADDR_W-1:0]   wa;
  logic [WORD_BITS-1:0] wd;
  logic                 re;
  logic [WADDR_W-1:0]   ra;

  assign op_alloc  = (in_opcode == OP_ALLOC);
  assign range_bad = ({1'b0, in_index} >= RANGE_LIM);

  assign scan_last = (rd_addr_r == LAST_ADDR);
  assign scan_word = rd_word_r | (scan_last ? PAD_MASK : '0);
  assign scan_inc  = scan_word + ONE;
  assign scan_free = ~&scan_word;

  assign bit_pos = idx_r[BIT_W-1:0];
  assign bit_oh  = ONE << bit_pos;
  assign was     = rd_word_r[bit_pos];
  assign do_set  = (op_r == OP_INSERT) && !was;
  assign do_clr  = (op_r == OP_REMOVE) && was;

  always_comb begin
    sts           = '0;
    sts.op_alloc  = op_alloc;
    sts.range_bad = range_bad;
    sts.scan_free = scan_free;
    sts.scan_last = scan_last;
    sts.clr_last  = (clr_addr_r == LAST_ADDR);
    sts.out_free  = !out_valid_r || out_ready;
  end

  // memory port selection
  always_comb begin
    we = 1'b0;
    wa = clr_addr_r;
    wd = '0;
    re = 1'b0;
    ra = '0;
    if (cmd.clr_step) begin
      we = 1'b1;
    end
    if (cmd.sgl_eval && (do_set || do_clr)) begin
      we = 1'b1;
      wa = rd_addr_r;
      wd = do_set ? (rd_word_r | bit_oh) : (rd_word_r & ~bit_oh);
    end
    if (cmd.scan_eval && scan_free) begin
      // setting the lowest clear bit: w | (w + 1)
      we = 1'b1;
      wa = rd_addr_r;
      wd = scan_word | scan_inc;
    end
    if (cmd.accept && op_alloc) begin
      re = 1'b1;
    end else if (cmd.accept && !range_bad) begin
      re = 1'b1;
      ra = in_index[BIT_W +: WADDR_W];
    end
    if (cmd.scan_eval && !scan_free && !scan_last) begin
      re = 1'b1;
      ra = rd_addr_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    if (re) begin
      rd_word_r <= mem[ra];
      rd_addr_r <= ra;
    end
  end

  always_comb begin
    count_nxt = count_r;
    if (cmd.sgl_eval && do_set) begin
      count_nxt = count_r + 1'b1;
    end else if (cmd.sgl_eval && do_clr) begin
      count_nxt = count_r - 1'b1;
    end else if (cmd.scan_eval && scan_free) begin
      count_nxt = count_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_addr_r  <= '0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.clr_step) begin
        clr_addr_r <= clr_addr_r + 1'b1;
      end
      count_r <= count_nxt;
      if (cmd.load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // result staging and output register
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      op_r         <= in_opcode;
      idx_r        <= in_index;
      res_was_r    <= 1'b0;
      alloc_ok_r   <= 1'b0;
      res_status_r <= ST_RANGE;
    end
    if (cmd.sgl_eval) begin
      res_was_r    <= was;
      res_status_r <= ST_OK;
    end
    if (cmd.scan_eval && scan_free) begin
      alloc_ok_r   <= 1'b1;
      hit_addr_r   <= rd_addr_r;
      iso_r        <= ~scan_word & scan_inc;
      res_status_r <= ST_OK;
    end else if (cmd.scan_eval && scan_last) begin
      res_status_r <= ST_FULL;
    end
    if (cmd.load_out) begin
      out_was_r    <= res_was_r;
      out_status_r <= res_status_r;
      out_count_r  <= CNT_OUT_W'(count_r);
      out_alloc_r  <= alloc_ok_r ? IDX_W'({hit_addr_r, oh_enc(iso_r)}) : '0;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_was_member   = out_was_r;
  assign out_alloc_index  = out_alloc_r;
  assign out_status       = out_status_r;
  assign out_member_count = out_count_r;

endmodule

// File: rtl/bitmap_id_allocator.sv
// Bitmap ID allocator. An accepted request runs IDLE -> SGL -> FIN for insert/remove/test,
// IDLE -> FIN for an out-of-range request and IDLE -> SCAN -> FIN for allocate, which scans k
// words (at most ceil(NUM_IDS/WORD_BITS), 8 at the defaults) one word per cycle; FIN loads
// the result register once it is free. One request in flight; the next is accepted the cycle
// after the result is loaded, even while that result still waits. Reset (rst_n, synchronous,
// low) starts a clearing pass over every bitmap word, during which no requests are taken.
//
// Depends on bmid_pkg, bmid_if, bmid_ctrl and bmid_dp.
module bitmap_id_allocator import bmid_pkg::*; #(
  parameter int NUM_IDS   = DEF_NUM_IDS,   // 32 .. 65536
  parameter int WORD_BITS = DEF_WORD_BITS  // power of two, 8 .. 64
) (
  input  logic       clk,
  input  logic       rst_n,
  bmid_req_if.sink   in_ch,
  bmid_rsp_if.source out_ch
);

  // The controller only sequences; every data decision (range check, free-bit
  // search, bitmap update, count) lives in the datapath and comes back as status.
  bmid_cmd_t cmd;
  bmid_sts_t sts;

  logic in_ready;

  bmid_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // Bitmap words live in a single-port-write memory; allocate streams words
  // out one per cycle and stops at the first one with a clear bit or at the last word.
  bmid_dp #(
    .NUM_IDS   (NUM_IDS),
    .WORD_BITS (WORD_BITS)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .sts              (sts),
    .in_opcode        (in_ch.opcode),
    .in_index         (in_ch.index),
    .out_valid        (out_ch.valid),
    .out_ready        (out_ch.ready),
    .out_was_member   (out_ch.was_member),
    .out_alloc_index  (out_ch.alloc_index),
    .out_status       (out_ch.status),
    .out_member_count (out_ch.member_count)
  );

  assign in_ch.ready = in_ready;

endmodule

// File: rtl/bmid_checker.sv
// Port-level assertions for the bitmap ID allocator, bound to the top level.
// Depends on bmid_pkg and assert_macros.svh.
`include "assert_macros.svh"

module bmid_checker import bmid_pkg::*; #(
  parameter int NUM_IDS = DEF_NUM_IDS
) (
  input logic                 clk,
  input logic                 rst_n,
  input logic                 in_ready,
  input logic                 out_valid,
  input logic                 out_ready,
  input logic                 out_was_member,
  input logic [IDX_W-1:0]     out_alloc_index,
  input logic [ST_W-1:0]      out_status,
  input logic [CNT_OUT_W-1:0] out_member_count
);

  // clearing pass keeps requests out right after reset
  `BMID_ASSERT_IMP(a_clr_after_rst, clk, rst_n, $past(!rst_n), !in_ready, "ready during clear")

  `BMID_ASSERT_NXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid, "result dropped")

  `BMID_ASSERT_IMP(a_full_res, clk, rst_n, out_valid && (out_status == ST_FULL), (out_alloc_index == '0) && !out_was_member && (out_member_count == CNT_OUT_W'(NUM_IDS)), "bad full result")

  `BMID_ASSERT_IMP(a_range_res, clk, rst_n, out_valid && (out_status == ST_RANGE), (out_alloc_index == '0) && !out_was_member, "bad range result")

  `BMID_ASSERT_IMP(a_member_res, clk, rst_n, out_valid && out_was_member, (out_status == ST_OK) && (out_alloc_index == '0), "bad member result")

endmodule

bind bitmap_id_allocator bmid_checker #(.NUM_IDS(NUM_IDS)) u_bmid_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_ready         (in_ch.ready),
  .out_valid        (out_ch.valid),
  .out_ready        (out_ch.ready),
  .out_was_member   (out_ch.was_member),
  .out_alloc_index  (out_ch.alloc_index),
  .out_status       (out_ch.status),
  .out_member_count (out_ch.member_count)
);

// File: tb/sv/tb.sv
// Self-checking testbench for bitmap_id_allocator: directed, fill and random request runs.
// A predictor keeps its own copy of the bitmap and count and checks every response.
// Depends on bmid_pkg, bmid_if and the bitmap_id_allocator RTL.
`timescale 1ns / 1ps

module tb;
  import bmid_pkg::*;

  localparam int NUM_IDS      = DEF_NUM_IDS;
  localparam int IDLE_LIMIT   = 4000;  // cycles with no handshake before the run is called hung
  localparam int DRAIN_CYCLES = 16;    // length of the quiet tail after the last response

  // One expected response, at the widths of the response channel.
  typedef struct {
    logic                 was_member;
    logic [IDX_W-1:0]     alloc_index;
    logic [ST_W-1:0]      status;
    logic [CNT_OUT_W-1:0] member_count;
  } id_result_t;

  logic clk;
  logic rst_n;

  bmid_req_if req_bus ();
  bmid_rsp_if rsp_bus ();

  bitmap_id_allocator DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (req_bus),
    .out_ch (rsp_bus)
  );

  // Predictor state: which ids are taken and how many.
  logic [NUM_IDS-1:0] id_map;
  int unsigned        id_count;

  id_result_t  pending_results[$];
  int unsigned err_cnt;
  int unsigned src_idle_pct;
  int unsigned snk_stall_pct;
  int unsigned quiet_cycles;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Apply one request to the predictor state and return what the block should answer.
  function automatic id_result_t apply_id_op(logic [OP_W-1:0] opcode, logic [IDX_W-1:0] index);
    id_result_t r;
    logic       found;
    r.was_member  = 1'b0;
    r.alloc_index = '0;
    r.status      = ST_OK;
    found         = 1'b0;
    if (opcode == OP_ALLOC) begin
      // lowest clear id wins; a full table leaves everything as is
      for (int slot = 0; slot < NUM_IDS; slot++) begin
        if (!found && !id_map[slot]) begin
          found         = 1'b1;
          id_map[slot]  = 1'b1;
          id_count++;
          r.alloc_index = IDX_W'(slot);
        end
      end
      if (!found) r.status = ST_FULL;
    end else if (index >= NUM_IDS) begin
      r.status = ST_RANGE;
    end else begin
      r.was_member = id_map[index];
      if (opcode == OP_INSERT && !r.was_member) begin
        id_map[index] = 1'b1;
        id_count++;
      end else if (opcode == OP_REMOVE && r.was_member) begin
        id_map[index] = 1'b0;
        id_count--;
      end
    end
    r.member_count = CNT_OUT_W'(id_count);
    return r;
  endfunction

  task automatic set_idling(int unsigned src_pct, int unsigned snk_pct);
    src_idle_pct  = src_pct;
    snk_stall_pct = snk_pct;
  endtask

  // Send one request. Called at a rising edge; returns at the edge that accepts it.
  // valid stays high into the next request unless an idle gap is drawn.
  task automatic issue_request(logic [OP_W-1:0] opcode, logic [IDX_W-1:0] index);
    if ($urandom_range(99) < src_idle_pct) begin
      req_bus.valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < src_idle_pct);
    end
    req_bus.valid  <= 1'b1;
    req_bus.opcode <= opcode;
    req_bus.index  <= index;
    do @(posedge clk); while (!req_bus.ready);
    pending_results.push_back(apply_id_op(opcode, index));
  endtask

  task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      err_cnt++;
    end
  endtask

  // Mostly in-range ids, some edge values, some anywhere in the 16-bit field.
  function automatic logic [IDX_W-1:0] pick_index();
    int unsigned roll;
    roll = $urandom_range(99);
    if (roll < 65) return IDX_W'($urandom_range(NUM_IDS - 1));
    if (roll < 75) begin
      case ($urandom_range(3))
        0:       return '0;
        1:       return IDX_W'(NUM_IDS - 1);
        2:       return IDX_W'(NUM_IDS);
        default: return '1;
      endcase
    end
    return IDX_W'($urandom_range(16'hFFFF));
  endfunction

  // Response monitor: each accepted response is matched against the oldest prediction.
  always @(posedge clk) begin
    id_result_t want;
    if (rst_n && rsp_bus.valid && rsp_bus.ready) begin
      if (pending_results.size() == 0) begin
        $error("response with no request outstanding");
        err_cnt++;
      end else begin
        want = pending_results.pop_front();
        check_field("was_member", 32'(want.was_member), 32'(rsp_bus.was_member));
        check_field("alloc_index", 32'(want.alloc_index), 32'(rsp_bus.alloc_index));
        check_field("status", 32'(want.status), 32'(rsp_bus.status));
        check_field("member_count", 32'(want.member_count), 32'(rsp_bus.member_count));
      end
    end
  end

  // Response back-pressure, redrawn every cycle.
  initial begin
    rsp_bus.ready <= 1'b0;
    forever begin
      @(posedge clk);
      rsp_bus.ready <= ($urandom_range(99) >= snk_stall_pct);
    end
  end

  // Watchdog: too long without any handshake on either side means a hang.
  always @(posedge clk) begin
    if (!rst_n || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= IDLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Every documented corner once: repeated insert/remove, range errors, first allocations.
  task automatic test_directed();
    set_idling(0, 0);
    issue_request(OP_INSERT, 16'd0);
    issue_request(OP_INSERT, 16'd0);          // already set
    issue_request(OP_TEST,   16'd0);
    issue_request(OP_REMOVE, 16'd0);
    issue_request(OP_REMOVE, 16'd0);          // already clear
    issue_request(OP_TEST,   16'd0);
    issue_request(OP_INSERT, 16'(NUM_IDS - 1));
    issue_request(OP_TEST,   16'(NUM_IDS - 1));
    issue_request(OP_INSERT, 16'(NUM_IDS));   // just out of range
    issue_request(OP_REMOVE, 16'hFFFF);
    issue_request(OP_TEST,   16'(NUM_IDS));
    issue_request(OP_INSERT, 16'h8000);
    issue_request(OP_ALLOC,  16'hFFFF);       // index is ignored by allocate
    issue_request(OP_ALLOC,  16'd0);
    issue_request(OP_INSERT, 16'd2);
    issue_request(OP_ALLOC,  16'h5555);       // skips the inserted id
    issue_request(OP_REMOVE, 16'd1);
    issue_request(OP_ALLOC,  16'd0);          // reuses the freed hole
    issue_request(OP_TEST,   16'd1);
    issue_request(OP_INSERT, 16'd31);
    issue_request(OP_INSERT, 16'd32);         // word boundary
    issue_request(OP_ALLOC,  16'hAAAA);
  endtask

  // Allocate until full, hit the full case, then punch holes and refill them.
  task automatic test_fill_table();
    set_idling(23, 23);
    while (id_count < NUM_IDS) issue_request(OP_ALLOC, pick_index());
    repeat (3) issue_request(OP_ALLOC, pick_index());
    issue_request(OP_INSERT, 16'd100);
    issue_request(OP_TEST,   16'(NUM_IDS - 1));
    issue_request(OP_REMOVE, 16'd200);
    issue_request(OP_REMOVE, 16'd77);
    issue_request(OP_REMOVE, 16'(NUM_IDS - 1));  // hole in the last word
    issue_request(OP_ALLOC,  16'd0);
    issue_request(OP_ALLOC,  16'd0);
    issue_request(OP_ALLOC,  16'd0);
    issue_request(OP_ALLOC,  16'd0);              // full again
  endtask

  // Random traffic in each idling mode; each mode grows the table, then leans toward removes.
  task automatic test_random_traffic();
    int unsigned      roll;
    logic [OP_W-1:0]  opcode;
    for (int mode = 0; mode < 4; mode++) begin
      case (mode)
        0:       set_idling(0, 0);
        1:       set_idling(75, 0);
        2:       set_idling(0, 75);
        default: set_idling(23, 23);
      endcase
      for (int n = 0; n < 165; n++) begin
        roll = $urandom_range(99);
        if (n < 90) begin
          opcode = (roll < 40) ? OP_ALLOC : (roll < 70) ? OP_INSERT :
                   (roll < 85) ? OP_TEST : OP_REMOVE;
        end else begin
          opcode = (roll < 10) ? OP_ALLOC : (roll < 25) ? OP_INSERT :
                   (roll < 40) ? OP_TEST : OP_REMOVE;
        end
        issue_request(opcode, pick_index());
      end
    end
  endtask

  initial begin
    id_map       = '0;
    id_count     = 0;
    err_cnt      = 0;
    quiet_cycles = 0;
    set_idling(0, 0);
    rst_n          <= 1'b0;
    req_bus.valid  <= 1'b0;
    req_bus.opcode <= OP_INSERT;
    req_bus.index  <= '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    // the block's clearing pass after reset is covered by waiting on ready

    test_directed();
    test_fill_table();
    test_random_traffic();

    // stop sending, let every outstanding response out, then a short quiet tail
    req_bus.valid <= 1'b0;
    set_idling(0, 0);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (err_cnt == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// File: bitmap_id_allocator.f
+incdir+rtl
rtl/bmid_pkg.sv
rtl/bmid_if.sv
rtl/bmid_ctrl.sv
rtl/bmid_dp.sv
rtl/bitmap_id_allocator.sv
rtl/bmid_checker.sv
tb/sv/tb.sv
